// ===== rtl/core/rfpd_pkg.sv =====
`default_nettype none

package rfpd_pkg;

   // Frame bytes and limits.
   localparam logic [7:0] HDR_BYTE  = 8'h02;
   localparam logic [7:0] TAIL_BYTE = 8'h03;
   localparam logic [7:0] LEN_MIN   = 8'h05;
   localparam logic [7:0] LEN_MAX   = 8'h0e;
   localparam logic [7:0] CMD_ON    = 8'h81;
   localparam logic [7:0] CMD_OFF   = 8'h82;
   localparam logic [7:0] CMD_TILE  = 8'h10;
   localparam int PAYLOAD_MAX = 9;

   // Result kinds.
   localparam logic [1:0] KIND_NEW    = 2'd0;
   localparam logic [1:0] KIND_REPEAT = 2'd1;
   localparam logic [1:0] KIND_OTHER  = 2'd2;

   // Register map.
   localparam int CSR_AW = 3;
   localparam logic REG_BYTE_GAP      = 1'b0;
   localparam logic REG_REPEAT_WINDOW = 1'b1;
   localparam logic [15:0] BYTE_GAP_RESET      = 16'd100;
   localparam logic [15:0] REPEAT_WINDOW_RESET = 16'd1000;

   // Tile history.
   localparam int HISTORY_DEPTH = 10;
   localparam int TILE_BYTES    = 9;
   localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int HIST_SW = $clog2(2 * HISTORY_DEPTH);
   localparam int ENTRY_W = 64 + 8 + 32;
   localparam logic [63:0] TILE_MASK_LO =
      (TILE_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * TILE_BYTES)) - 64'd1);
   localparam logic [7:0] TILE_MASK_HI = (TILE_BYTES >= 9) ? 8'hff : 8'h00;

   typedef struct packed {
      logic take_byte;
      logic start_frame;
      logic load_len;
      logic load_cmd;
      logic store_byte;
      logic walk_start;
      logic walk_step;
      logic mark_repeat;
      logic push;
      logic emit;
      logic emit_tile;
   } rfpd_cmd_type;

   typedef struct packed {
      logic gap_expired;
      logic is_hdr;
      logic len_ok;
      logic cmd_ok;
      logic len_gt_min;
      logic payload_done;
      logic xor_ok;
      logic is_tail;
      logic cmd_tile;
      logic entry_young;
      logic entry_match;
      logic walk_last;
      logic fill_zero;
      logic out_block;
   } rfpd_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/rfpd_req_if.sv =====
`default_nettype none

interface rfpd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic [31:0] time_ms;

   modport source (output valid, rx_byte, time_ms, input ready);
   modport sink (input valid, rx_byte, time_ms, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rfpd_rsp_if.sv =====
`default_nettype none

interface rfpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  frame_kind;
   logic [3:0]  frame_length;
   logic [7:0]  frame_command;
   logic [63:0] payload_low;
   logic [7:0]  payload_high;

   modport source (output valid, frame_kind, frame_length, frame_command, payload_low,
                   payload_high, input ready);
   modport sink (input valid, frame_kind, frame_length, frame_command, payload_low,
                 payload_high, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rfpd_ram.sv =====
`default_nettype none

module rfpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

// ===== rtl/core/rfpd_ctrl.sv =====
`default_nettype none

module rfpd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire rfpd_pkg::rfpd_stat_type stat,
   output rfpd_pkg::rfpd_cmd_type       cmd
);
   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_LEN     = 3'd1;
   localparam logic [2:0] PH_CMD     = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CHECK   = 3'd4;
   localparam logic [2:0] PH_TAIL    = 3'd5;

   localparam logic [1:0] SQ_IDLE = 2'd0;
   localparam logic [1:0] SQ_CMP  = 2'd1;
   localparam logic [1:0] SQ_PUSH = 2'd2;

   logic [2:0] phase_ff, phase_in, cur_phase;
   logic [1:0] seq_ff, seq_in;
   logic       beat;

   assign req_ready = (seq_ff == SQ_IDLE) && !stat.out_block;
   assign beat      = req_valid && req_ready;
   // A long silence restarts the hunt before the byte itself is looked at.
   assign cur_phase = stat.gap_expired ? PH_HUNT : phase_ff;

   always_comb begin
      cmd      = '0;
      phase_in = phase_ff;
      seq_in   = seq_ff;
      case (seq_ff)
         SQ_IDLE: begin
            if (beat) begin
               cmd.take_byte = 1'b1;
               phase_in      = PH_HUNT;
               case (cur_phase)
                  PH_HUNT: begin
                     if (stat.is_hdr) begin
                        cmd.start_frame = 1'b1;
                        phase_in        = PH_LEN;
                     end
                  end
                  PH_LEN: begin
                     if (stat.len_ok) begin
                        cmd.load_len = 1'b1;
                        phase_in     = PH_CMD;
                     end else if (stat.is_hdr) begin
                        phase_in = PH_LEN;
                     end
                  end
                  PH_CMD: begin
                     if (stat.cmd_ok) begin
                        cmd.load_cmd = 1'b1;
                        phase_in     = stat.len_gt_min ? PH_PAYLOAD : PH_CHECK;
                     end
                  end
                  PH_PAYLOAD: begin
                     cmd.store_byte = 1'b1;
                     phase_in       = stat.payload_done ? PH_CHECK : PH_PAYLOAD;
                  end
                  PH_CHECK: begin
                     if (stat.xor_ok) begin
                        phase_in = PH_TAIL;
                     end
                  end
                  PH_TAIL: begin
                     if (stat.is_tail) begin
                        if (stat.cmd_tile) begin
                           cmd.walk_start = 1'b1;
                           seq_in         = stat.fill_zero ? SQ_PUSH : SQ_CMP;
                        end else begin
                           cmd.emit = 1'b1;
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_HUNT;
                  end
               endcase
            end
         end
         SQ_CMP: begin
            if (stat.entry_young && stat.entry_match) begin
               cmd.mark_repeat = 1'b1;
               seq_in          = SQ_PUSH;
            end else if (!stat.entry_young || stat.walk_last) begin
               seq_in = SQ_PUSH;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         SQ_PUSH: begin
            cmd.push      = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_tile = 1'b1;
            seq_in        = SQ_IDLE;
         end
         default: begin
            seq_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         seq_ff   <= SQ_IDLE;
      end else begin
         phase_ff <= phase_in;
         seq_ff   <= seq_in;
      end
   end
endmodule

`default_nettype wire

// ===== rtl/core/rfpd_dp.sv =====
`default_nettype none

module rfpd_dp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rfpd_pkg::rfpd_cmd_type  cmd,
   output rfpd_pkg::rfpd_stat_type      stat,
   input  wire logic [7:0]              rx_byte,
   input  wire logic [31:0]             time_ms,
   input  wire logic [15:0]             byte_gap,
   input  wire logic [15:0]             repeat_window,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   frame_kind,
   output logic [3:0]                   frame_length,
   output logic [7:0]                   frame_command,
   output logic [63:0]                  payload_low,
   output logic [7:0]                   payload_high
);
   localparam int PAY_N = rfpd_pkg::PAYLOAD_MAX;
   localparam int HD    = rfpd_pkg::HISTORY_DEPTH;
   localparam int AW    = rfpd_pkg::HIST_AW;
   localparam int FW    = rfpd_pkg::FILL_W;
   localparam int SW    = rfpd_pkg::HIST_SW;

   // Frame registers.
   logic [3:0]  len_ff, len_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [3:0]  count_ff, count_in;
   logic [7:0]  xor_ff, xor_in;
   logic [31:0] last_ff, last_in;
   logic [7:0]  store_ff [PAY_N];
   logic [7:0]  store_in [PAY_N];

   // History walk registers.
   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [AW-1:0] k_ff, k_in;
   logic          repeat_ff, repeat_in;

   // Result register.
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [3:0]  olen_ff, olen_in;
   logic [7:0]  ocmd_ff, ocmd_in;
   logic [63:0] olo_ff, olo_in;
   logic [7:0]  ohi_ff, ohi_in;

   logic [63:0]  pay_lo, tile_lo;
   logic [7:0]   pay_hi, tile_hi;
   logic [31:0]  gap_diff, age;
   logic [SW-1:0] idx_sum;
   logic [AW-1:0] rd_addr;
   logic [rfpd_pkg::ENTRY_W-1:0] rd_data, wr_data;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         pay_lo[8*i +: 8] = store_ff[i];
      end
      pay_hi  = store_ff[8];
      tile_lo = pay_lo & rfpd_pkg::TILE_MASK_LO;
      tile_hi = pay_hi & rfpd_pkg::TILE_MASK_HI;
   end

   assign gap_diff = time_ms - last_ff;
   assign age      = last_ff - rd_data[103:72];

   // Entry k back from the newest: (head - 1 - k) modulo the depth.
   assign idx_sum = SW'(head_ff) + SW'(HD - 1) - SW'(k_in);
   assign rd_addr = (idx_sum >= SW'(HD)) ? AW'(idx_sum - SW'(HD)) : AW'(idx_sum);
   assign wr_data = {last_ff, tile_hi, tile_lo};

   rfpd_ram #(
      .WIDTH (rfpd_pkg::ENTRY_W),
      .DEPTH (HD)
   ) u_hist (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (head_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      stat.gap_expired  = gap_diff > {16'd0, byte_gap};
      stat.is_hdr       = rx_byte == rfpd_pkg::HDR_BYTE;
      stat.len_ok       = (rx_byte >= rfpd_pkg::LEN_MIN) && (rx_byte <= rfpd_pkg::LEN_MAX);
      stat.cmd_ok       = (rx_byte == rfpd_pkg::CMD_ON) || (rx_byte == rfpd_pkg::CMD_OFF) ||
                          (rx_byte == rfpd_pkg::CMD_TILE);
      stat.len_gt_min   = {4'd0, len_ff} > rfpd_pkg::LEN_MIN;
      stat.payload_done = ({4'd0, count_ff} + 8'd1 + rfpd_pkg::LEN_MIN >= {4'd0, len_ff}) ||
                          (count_ff + 4'd1 >= 4'(PAY_N));
      stat.xor_ok       = xor_ff == rx_byte;
      stat.is_tail      = rx_byte == rfpd_pkg::TAIL_BYTE;
      stat.cmd_tile     = cmd_ff == rfpd_pkg::CMD_TILE;
      stat.entry_young  = age < {16'd0, repeat_window};
      stat.entry_match  = (rd_data[63:0] == tile_lo) && (rd_data[71:64] == tile_hi);
      stat.walk_last    = (FW'(k_ff) + FW'(1)) == fill_ff;
      stat.fill_zero    = fill_ff == '0;
      stat.out_block    = out_valid_ff && !rsp_ready;
   end

   always_comb begin
      len_in    = len_ff;
      cmd_in    = cmd_ff;
      count_in  = count_ff;
      xor_in    = xor_ff;
      last_in   = last_ff;
      store_in  = store_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      k_in      = k_ff;
      repeat_in = repeat_ff;

      if (cmd.take_byte) begin
         last_in = time_ms;
      end
      if (cmd.start_frame) begin
         count_in = 4'd0;
         xor_in   = rfpd_pkg::HDR_BYTE;
         for (int i = 0; i < PAY_N; i++) begin
            store_in[i] = 8'd0;
         end
      end
      if (cmd.load_len) begin
         len_in = rx_byte[3:0];
         xor_in = xor_ff ^ rx_byte;
      end
      if (cmd.load_cmd) begin
         cmd_in   = rx_byte;
         count_in = 4'd0;
         xor_in   = xor_ff ^ rx_byte;
      end
      if (cmd.store_byte) begin
         for (int i = 0; i < PAY_N; i++) begin
            if (count_ff == 4'(i)) begin
               store_in[i] = rx_byte;
            end
         end
         count_in = count_ff + 4'd1;
         xor_in   = xor_ff ^ rx_byte;
      end
      if (cmd.walk_start) begin
         k_in      = '0;
         repeat_in = 1'b0;
      end
      if (cmd.walk_step) begin
         k_in = k_ff + AW'(1);
      end
      if (cmd.mark_repeat) begin
         repeat_in = 1'b1;
      end
      if (cmd.push) begin
         head_in = (head_ff == AW'(HD - 1)) ? '0 : head_ff + AW'(1);
         if (fill_ff < FW'(HD)) begin
            fill_in = fill_ff + FW'(1);
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      olen_in      = olen_ff;
      ocmd_in      = ocmd_ff;
      olo_in       = olo_ff;
      ohi_in       = ohi_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         olen_in      = len_ff;
         ocmd_in      = cmd_ff;
         olo_in       = pay_lo;
         ohi_in       = pay_hi;
         if (!cmd.emit_tile) begin
            kind_in = rfpd_pkg::KIND_OTHER;
         end else if (repeat_ff) begin
            kind_in = rfpd_pkg::KIND_REPEAT;
         end else begin
            kind_in = rfpd_pkg::KIND_NEW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= 4'd0;
         cmd_ff       <= 8'd0;
         count_ff     <= 4'd0;
         last_ff      <= 32'd0;
         head_ff      <= '0;
         fill_ff      <= '0;
         k_ff         <= '0;
         repeat_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         cmd_ff       <= cmd_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         k_ff         <= k_in;
         repeat_ff    <= repeat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xor_ff   <= xor_in;
      store_ff <= store_in;
      kind_ff  <= kind_in;
      olen_ff  <= olen_in;
      ocmd_ff  <= ocmd_in;
      olo_ff   <= olo_in;
      ohi_ff   <= ohi_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign frame_kind    = kind_ff;
   assign frame_length  = olen_ff;
   assign frame_command = ocmd_ff;
   assign payload_low   = olo_ff;
   assign payload_high  = ohi_ff;
endmodule

`default_nettype wire

// ===== rtl/core/reader_frame_parser_dedup.sv =====
`default_nettype none

// Channel   Dir  Protocol        Contents
// req_bus   in   valid/ready     rx_byte, time_ms
// rsp_bus   out  valid/ready     frame_kind, frame_length, frame_command, payload_low/high
// csr       in   APB, 2 x 16b    byte_gap_ms at 0x0, repeat_window_ms at 0x4
//
// The tail of a good tile frame walks the tile history, one entry per cycle from the
// history RAM's read port, and then pushes the tile; no new byte is taken until the walk and push are over.
// Synchronous reset clears the control state; the history RAM needs no clearing pass,
// since its fill count bounds the walk. A stalled result beat blocks new input beats.
module reader_frame_parser_dedup (
   input  wire logic                          clock,
   input  wire logic                          reset,
   rfpd_req_if.sink                           req_bus,
   rfpd_rsp_if.source                         rsp_bus,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [rfpd_pkg::CSR_AW-1:0]   paddr,
   input  wire logic [31:0]                   pwdata,
   output logic      [31:0]                   prdata,
   output logic                               pready
);
   logic [15:0] byte_gap_ff, byte_gap_in;
   logic [15:0] repeat_window_ff, repeat_window_in;
   logic        csr_write;
   logic        reg_sel;

   rfpd_pkg::rfpd_cmd_type  cmd;
   rfpd_pkg::rfpd_stat_type stat;

   assign pready    = 1'b1;
   assign reg_sel   = paddr[2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      byte_gap_in      = byte_gap_ff;
      repeat_window_in = repeat_window_ff;
      if (csr_write) begin
         case (reg_sel)
            rfpd_pkg::REG_BYTE_GAP:      byte_gap_in      = pwdata[15:0];
            rfpd_pkg::REG_REPEAT_WINDOW: repeat_window_in = pwdata[15:0];
            default: begin
               byte_gap_in = byte_gap_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         rfpd_pkg::REG_BYTE_GAP:      prdata = {16'd0, byte_gap_ff};
         rfpd_pkg::REG_REPEAT_WINDOW: prdata = {16'd0, repeat_window_ff};
         default:                     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_gap_ff      <= rfpd_pkg::BYTE_GAP_RESET;
         repeat_window_ff <= rfpd_pkg::REPEAT_WINDOW_RESET;
      end else begin
         byte_gap_ff      <= byte_gap_in;
         repeat_window_ff <= repeat_window_in;
      end
   end

   rfpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rfpd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .rx_byte       (req_bus.rx_byte),
      .time_ms       (req_bus.time_ms),
      .byte_gap      (byte_gap_ff),
      .repeat_window (repeat_window_ff),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .frame_kind    (rsp_bus.frame_kind),
      .frame_length  (rsp_bus.frame_length),
      .frame_command (rsp_bus.frame_command),
      .payload_low   (rsp_bus.payload_low),
      .payload_high  (rsp_bus.payload_high)
   );
endmodule

`default_nettype wire
